FILE: rtl/core/shtt_pkg.sv
// Shared types, constants and helpers for the three-axis segment hit test.
package shtt_pkg;

	// Default coordinate format: signed Q12.4 pixels.
	localparam int COORD_WIDTH_DEF = 16;
	localparam int COORD_FRAC_DEF  = 4;

	// Configuration registers are 15 bits unsigned.
	localparam int REG_W     = 15;
	localparam int SQR_W     = 2 * REG_W;
	localparam int CFG_IDX_W = 2;

	// Reset values of the radius and threshold in whole pixels.
	localparam int CENTER_RADIUS_PX  = 45;
	localparam int AXIS_THRESHOLD_PX = 55;

	// Digit width of the split multipliers.
	localparam int MUL_DIGIT = 17;

	// Axis slots, in the order that ties are resolved (first wins).
	localparam int NUM_AXES = 3;
	localparam int AX_Z     = 0;
	localparam int AX_Y     = 1;
	localparam int AX_X     = 2;

	// Pairwise distance comparisons: slot A is tested for being nearer than slot B.
	localparam int NUM_PAIRS = 3;
	localparam int PAIR_YZ   = 0;
	localparam int PAIR_XZ   = 1;
	localparam int PAIR_XY   = 2;
	localparam int PAIR_A [NUM_PAIRS] = '{AX_Y, AX_X, AX_X};
	localparam int PAIR_B [NUM_PAIRS] = '{AX_Z, AX_Z, AX_Y};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_RADIUS  = 2'd0,
		CFG_AXIS_THRESHOLD = 2'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		HIT_NONE   = 3'd0,
		HIT_CENTER = 3'd1,
		HIT_X      = 3'd2,
		HIT_Y      = 3'd3,
		HIT_Z      = 3'd4
	} hit_code_t;

	// Pipeline depth of the split multiplier: its leaf product registers and its adder tree levels.
	function automatic int mul_latency(input int aw, input int bw);
		int na;
		int nb;
		na = (aw + MUL_DIGIT - 1) / MUL_DIGIT;
		nb = (bw + MUL_DIGIT - 1) / MUL_DIGIT;
		return $clog2(na * nb) + 1;
	endfunction

endpackage

FILE: rtl/core/shtt_query_if.sv
// Query channel: visible flag, touch point, center point and three axis tips.
interface shtt_query_if #(
	parameter int COORD_WIDTH = shtt_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic                          handle_visible;
	logic signed [COORD_WIDTH-1:0] touch_x;
	logic signed [COORD_WIDTH-1:0] touch_y;
	logic signed [COORD_WIDTH-1:0] center_x;
	logic signed [COORD_WIDTH-1:0] center_y;
	logic signed [COORD_WIDTH-1:0] tip_x_x;
	logic signed [COORD_WIDTH-1:0] tip_x_y;
	logic signed [COORD_WIDTH-1:0] tip_y_x;
	logic signed [COORD_WIDTH-1:0] tip_y_y;
	logic signed [COORD_WIDTH-1:0] tip_z_x;
	logic signed [COORD_WIDTH-1:0] tip_z_y;

	modport source (
		output valid, handle_visible, touch_x, touch_y, center_x, center_y,
		output tip_x_x, tip_x_y, tip_y_x, tip_y_y, tip_z_x, tip_z_y,
		input  ready
	);

	modport sink (
		input  valid, handle_visible, touch_x, touch_y, center_x, center_y,
		input  tip_x_x, tip_x_y, tip_y_x, tip_y_y, tip_z_x, tip_z_y,
		output ready
	);
endinterface

FILE: rtl/core/shtt_result_if.sv
// Result channel: the code of the handle under the touch.
interface shtt_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] hit_handle;

	modport source (
		output valid, hit_handle,
		input  ready
	);

	modport sink (
		input  valid, hit_handle,
		output ready
	);
endinterface

FILE: rtl/core/shtt_mul.sv
// Pipelined unsigned multiplier built from narrow digit products and a registered adder tree.
module shtt_mul #(
	parameter int AW = 2 * shtt_pkg::COORD_WIDTH_DEF + 1,
	parameter int BW = 2 * shtt_pkg::COORD_WIDTH_DEF + 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic [AW+BW-1:0] p
);
	import shtt_pkg::*;

	localparam int PW    = AW + BW;
	localparam int NA    = (AW + MUL_DIGIT - 1) / MUL_DIGIT;
	localparam int NB    = (BW + MUL_DIGIT - 1) / MUL_DIGIT;
	localparam int AEW   = NA * MUL_DIGIT;
	localparam int BEW   = NB * MUL_DIGIT;
	localparam int NP    = NA * NB;
	localparam int LVL   = $clog2(NP);
	localparam int NL    = 1 << LVL;
	localparam int NODES = 2 * NL - 1;

	logic [AEW-1:0] a_ext;
	logic [BEW-1:0] b_ext;
	logic [PW-1:0]  node_q [NODES];

	assign a_ext = AEW'(a);
	assign b_ext = BEW'(b);

	// Leaves: one digit-by-digit product each, already shifted into place.
	for (genvar j = 0; j < NL; j++) begin : g_leaf
		if (j < NP) begin : g_pp
			localparam int IA = j / NB;
			localparam int IB = j % NB;
			logic [2*MUL_DIGIT-1:0] pp;
			assign pp = a_ext[IA*MUL_DIGIT +: MUL_DIGIT] * b_ext[IB*MUL_DIGIT +: MUL_DIGIT];
			always_ff @(posedge clk) begin
				if (en) begin
					node_q[NL-1+j] <= PW'(pp) << (MUL_DIGIT * (IA + IB));
				end
			end
		end else begin : g_pad
			always_ff @(posedge clk) begin
				if (en) begin
					node_q[NL-1+j] <= '0;
				end
			end
		end
	end

	// Tree nodes: each level adds two children and registers the sum.
	for (genvar i = 0; i < NL - 1; i++) begin : g_node
		always_ff @(posedge clk) begin
			if (en) begin
				node_q[i] <= node_q[2*i+1] + node_q[2*i+2];
			end
		end
	end

	assign p = node_q[0];

endmodule

FILE: rtl/core/segment_hit_test_three_axes_unit.sv
// Three-axis handle hit test. The unit accepts one query per clock while ready is high and
// returns one hit code per query, in order. A query passes the difference, product, sum and
// region stages, the first split multiplier (squaring the cross product), the ratio stage,
// the second split multipliers (cross-multiplying the distance ratios) and the winner stage.
// Distances are compared exactly as squared ratios, so no divider is involved. A single
// output holding stage lets the unit take a further transaction while a result waits;
// when that stage is occupied the pipeline holds and ready is low. Configuration writes
// store the squared radius and threshold and also act on queries still before the compares.
module segment_hit_test_three_axes_unit #(
	parameter int COORD_WIDTH     = shtt_pkg::COORD_WIDTH_DEF,
	parameter int COORD_FRAC_BITS = shtt_pkg::COORD_FRAC_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	shtt_query_if.sink                      query,
	shtt_result_if.source                   result,
	input  logic                            cfg_we,
	input  logic [shtt_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [shtt_pkg::REG_W-1:0]      cfg_wdata
);
	import shtt_pkg::*;

	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int SQ_W   = 2 * COORD_WIDTH;
	localparam int PR_W   = 2 * COORD_WIDTH + 1;
	localparam int DOT_W  = 2 * COORD_WIDTH + 2;
	localparam int LEN_W  = 2 * COORD_WIDTH + 1;
	localparam int MAG_W  = 2 * COORD_WIDTH + 1;
	localparam int NUM_W  = 2 * MAG_W;
	localparam int DEN_W  = LEN_W;
	localparam int CMP_W  = NUM_W + DEN_W;
	localparam int CR_W   = (LEN_W > SQR_W) ? LEN_W : SQR_W;
	localparam int L1     = mul_latency(MAG_W, MAG_W);
	localparam int L2     = mul_latency(NUM_W, DEN_W);

	localparam logic [REG_W-1:0] R_RST  = REG_W'(CENTER_RADIUS_PX << COORD_FRAC_BITS);
	localparam logic [REG_W-1:0] T_RST  = REG_W'(AXIS_THRESHOLD_PX << COORD_FRAC_BITS);
	localparam logic [SQR_W-1:0] R2_RST = SQR_W'(R_RST) * SQR_W'(R_RST);
	localparam logic [SQR_W-1:0] T2_RST = SQR_W'(T_RST) * SQR_W'(T_RST);

	typedef struct packed {
		logic                                vis;
		logic                                ctr;
		logic [NUM_AXES-1:0]                 interior;
		logic [NUM_AXES-1:0][LEN_W-1:0]      num_end;
		logic [NUM_AXES-1:0][DEN_W-1:0]      den;
	} side1_t;

	typedef struct packed {
		logic                                vis;
		logic                                ctr;
		logic [NUM_AXES-1:0][NUM_W-1:0]      num;
	} side2_t;

	// Pipeline advance: the whole pipe holds only while the output holding stage is full.
	logic adv;
	logic skid_v_q;
	logic [2:0] skid_hit_q;

	// Configuration: squared radius and threshold.
	logic [SQR_W-1:0] r2_q;
	logic [SQR_W-1:0] t2_q;
	logic [SQR_W-1:0] cfg_sq;

	// Stage 1: coordinate differences.
	logic signed [COORD_WIDTH-1:0] tip_xv [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] tip_yv [NUM_AXES];
	logic                      v_s1;
	logic                      vis_s1;
	logic signed [DIFF_W-1:0]  wx_s1, wy_s1;
	logic signed [DIFF_W-1:0]  vx_s1 [NUM_AXES];
	logic signed [DIFF_W-1:0]  vy_s1 [NUM_AXES];
	logic signed [DIFF_W-1:0]  ex_s1 [NUM_AXES];
	logic signed [DIFF_W-1:0]  ey_s1 [NUM_AXES];

	// Stage 2: products.
	logic signed [PR_W-1:0] wxwx, wywy;
	logic signed [PR_W-1:0] dota [NUM_AXES];
	logic signed [PR_W-1:0] dotb [NUM_AXES];
	logic signed [PR_W-1:0] lena [NUM_AXES];
	logic signed [PR_W-1:0] lenb [NUM_AXES];
	logic signed [PR_W-1:0] crsa [NUM_AXES];
	logic signed [PR_W-1:0] crsb [NUM_AXES];
	logic signed [PR_W-1:0] enda [NUM_AXES];
	logic signed [PR_W-1:0] endb [NUM_AXES];
	logic                   v_s2;
	logic                   vis_s2;
	logic [SQ_W-1:0]        wxwx_s2, wywy_s2;
	logic signed [PR_W-1:0] dota_s2 [NUM_AXES];
	logic signed [PR_W-1:0] dotb_s2 [NUM_AXES];
	logic [SQ_W-1:0]        lena_s2 [NUM_AXES];
	logic [SQ_W-1:0]        lenb_s2 [NUM_AXES];
	logic signed [PR_W-1:0] crsa_s2 [NUM_AXES];
	logic signed [PR_W-1:0] crsb_s2 [NUM_AXES];
	logic [SQ_W-1:0]        enda_s2 [NUM_AXES];
	logic [SQ_W-1:0]        endb_s2 [NUM_AXES];

	// Stage 3: dot products, squared lengths and cross products.
	logic                    v_s3;
	logic                    vis_s3;
	logic [LEN_W-1:0]        w2_s3;
	logic signed [DOT_W-1:0] c1_s3 [NUM_AXES];
	logic [LEN_W-1:0]        c2_s3 [NUM_AXES];
	logic signed [DOT_W-1:0] cr_s3 [NUM_AXES];
	logic [LEN_W-1:0]        e2_s3 [NUM_AXES];

	// Stage 4: segment region, end point distances and cross product magnitude.
	logic                    v_s4;
	side1_t                  sd_s4;
	logic [MAG_W-1:0]        mag_s4 [NUM_AXES];
	logic signed [DOT_W-1:0] cr_neg [NUM_AXES];

	// First multiplier and its side delay line.
	logic [NUM_W-1:0] crsq [NUM_AXES];
	side1_t           sd1_q [L1];
	logic [L1-1:0]    vd1_q;
	side1_t           sd1;

	// Stage 5: distance ratios.
	logic                        v_s5;
	logic                        vis_s5;
	logic                        ctr_s5;
	logic [NUM_W-1:0]            num_s5 [NUM_AXES];
	logic [DEN_W-1:0]            den_s5 [NUM_AXES];
	side2_t                      sd_s5;

	// Second multiplier set and its side delay line.
	logic [CMP_W-1:0] pa [NUM_PAIRS];
	logic [CMP_W-1:0] pb [NUM_PAIRS];
	logic [CMP_W-1:0] pthr [NUM_AXES];
	side2_t           sd2_q [L2];
	logic [L2-1:0]    vd2_q;
	side2_t           sd2;

	// Stage 6: winner selection.
	logic [NUM_PAIRS-1:0] lt;
	logic [NUM_AXES-1:0]  below;
	logic                 win_z, win_y, win_x;
	hit_code_t            hit_nx;
	logic                 v_s6;
	logic [2:0]           hit_s6;

	assign adv = !skid_v_q;

	// Configuration registers hold squares so the pipeline compares squared distances.
	assign cfg_sq = SQR_W'(cfg_wdata) * SQR_W'(cfg_wdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r2_q <= R2_RST;
			t2_q <= T2_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				CFG_CENTER_RADIUS:  r2_q <= cfg_sq;
				CFG_AXIS_THRESHOLD: t2_q <= cfg_sq;
				default: ;
			endcase
		end
	end

	// Axis tips in tie order.
	assign tip_xv[AX_Z] = query.tip_z_x;
	assign tip_yv[AX_Z] = query.tip_z_y;
	assign tip_xv[AX_Y] = query.tip_y_x;
	assign tip_yv[AX_Y] = query.tip_y_y;
	assign tip_xv[AX_X] = query.tip_x_x;
	assign tip_yv[AX_X] = query.tip_x_y;

	assign query.ready = adv;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			vd1_q <= '0;
			v_s5  <= 1'b0;
			vd2_q <= '0;
			v_s6  <= 1'b0;
		end else if (adv) begin
			v_s1     <= query.valid;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			vd1_q[0] <= v_s4;
			for (int i = 1; i < L1; i++) begin
				vd1_q[i] <= vd1_q[i-1];
			end
			v_s5     <= vd1_q[L1-1];
			vd2_q[0] <= v_s5;
			for (int i = 1; i < L2; i++) begin
				vd2_q[i] <= vd2_q[i-1];
			end
			v_s6     <= vd2_q[L2-1];
		end
	end

	// Stage 1: vectors from the center to the touch and to each tip, and tip to touch.
	always_ff @(posedge clk) begin
		if (adv) begin
			vis_s1 <= query.handle_visible;
			wx_s1  <= DIFF_W'(query.touch_x) - DIFF_W'(query.center_x);
			wy_s1  <= DIFF_W'(query.touch_y) - DIFF_W'(query.center_y);
			for (int k = 0; k < NUM_AXES; k++) begin
				vx_s1[k] <= DIFF_W'(tip_xv[k]) - DIFF_W'(query.center_x);
				vy_s1[k] <= DIFF_W'(tip_yv[k]) - DIFF_W'(query.center_y);
				ex_s1[k] <= DIFF_W'(query.touch_x) - DIFF_W'(tip_xv[k]);
				ey_s1[k] <= DIFF_W'(query.touch_y) - DIFF_W'(tip_yv[k]);
			end
		end
	end

	// Stage 2: one multiplier per product term.
	assign wxwx = PR_W'(wx_s1) * PR_W'(wx_s1);
	assign wywy = PR_W'(wy_s1) * PR_W'(wy_s1);
	for (genvar k = 0; k < NUM_AXES; k++) begin : g_prod
		assign dota[k] = PR_W'(wx_s1) * PR_W'(vx_s1[k]);
		assign dotb[k] = PR_W'(wy_s1) * PR_W'(vy_s1[k]);
		assign lena[k] = PR_W'(vx_s1[k]) * PR_W'(vx_s1[k]);
		assign lenb[k] = PR_W'(vy_s1[k]) * PR_W'(vy_s1[k]);
		assign crsa[k] = PR_W'(wx_s1) * PR_W'(vy_s1[k]);
		assign crsb[k] = PR_W'(wy_s1) * PR_W'(vx_s1[k]);
		assign enda[k] = PR_W'(ex_s1[k]) * PR_W'(ex_s1[k]);
		assign endb[k] = PR_W'(ey_s1[k]) * PR_W'(ey_s1[k]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vis_s2  <= vis_s1;
			wxwx_s2 <= wxwx[SQ_W-1:0];
			wywy_s2 <= wywy[SQ_W-1:0];
			for (int k = 0; k < NUM_AXES; k++) begin
				dota_s2[k] <= dota[k];
				dotb_s2[k] <= dotb[k];
				lena_s2[k] <= lena[k][SQ_W-1:0];
				lenb_s2[k] <= lenb[k][SQ_W-1:0];
				crsa_s2[k] <= crsa[k];
				crsb_s2[k] <= crsb[k];
				enda_s2[k] <= enda[k][SQ_W-1:0];
				endb_s2[k] <= endb[k][SQ_W-1:0];
			end
		end
	end

	// Stage 3: sums of the product terms.
	always_ff @(posedge clk) begin
		if (adv) begin
			vis_s3 <= vis_s2;
			w2_s3  <= LEN_W'(wxwx_s2) + LEN_W'(wywy_s2);
			for (int k = 0; k < NUM_AXES; k++) begin
				c1_s3[k] <= DOT_W'(dota_s2[k]) + DOT_W'(dotb_s2[k]);
				c2_s3[k] <= LEN_W'(lena_s2[k]) + LEN_W'(lenb_s2[k]);
				cr_s3[k] <= DOT_W'(crsa_s2[k]) - DOT_W'(crsb_s2[k]);
				e2_s3[k] <= LEN_W'(enda_s2[k]) + LEN_W'(endb_s2[k]);
			end
		end
	end

	// Stage 4: classify where the touch projects onto each segment.
	for (genvar k = 0; k < NUM_AXES; k++) begin : g_neg
		assign cr_neg[k] = -cr_s3[k];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s4.vis <= vis_s3;
			sd_s4.ctr <= CR_W'(w2_s3) < CR_W'(r2_q);
			for (int k = 0; k < NUM_AXES; k++) begin
				if (c1_s3[k][DOT_W-1] || c1_s3[k] == '0) begin
					// Projection falls before the center end.
					sd_s4.num_end[k]  <= w2_s3;
					sd_s4.interior[k] <= 1'b0;
					sd_s4.den[k]      <= DEN_W'(1);
				end else if ($signed({1'b0, c2_s3[k]}) <= c1_s3[k]) begin
					// Projection falls beyond the tip end.
					sd_s4.num_end[k]  <= e2_s3[k];
					sd_s4.interior[k] <= 1'b0;
					sd_s4.den[k]      <= DEN_W'(1);
				end else begin
					// Perpendicular distance: cross squared over length squared.
					sd_s4.num_end[k]  <= e2_s3[k];
					sd_s4.interior[k] <= 1'b1;
					sd_s4.den[k]      <= c2_s3[k];
				end
				mag_s4[k] <= cr_s3[k][DOT_W-1] ? MAG_W'(cr_neg[k]) : MAG_W'(cr_s3[k]);
			end
		end
	end

	// Square the cross product magnitudes.
	for (genvar k = 0; k < NUM_AXES; k++) begin : g_sq
		shtt_mul #(
			.AW (MAG_W),
			.BW (MAG_W)
		) u_sq (
			.clk (clk),
			.en  (adv),
			.a   (mag_s4[k]),
			.b   (mag_s4[k]),
			.p   (crsq[k])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd1_q[0] <= sd_s4;
			for (int i = 1; i < L1; i++) begin
				sd1_q[i] <= sd1_q[i-1];
			end
		end
	end
	assign sd1 = sd1_q[L1-1];

	// Stage 5: each distance as a ratio num / den.
	always_ff @(posedge clk) begin
		if (adv) begin
			vis_s5 <= sd1.vis;
			ctr_s5 <= sd1.ctr;
			for (int k = 0; k < NUM_AXES; k++) begin
				num_s5[k] <= sd1.interior[k] ? crsq[k] : NUM_W'(sd1.num_end[k]);
				den_s5[k] <= sd1.den[k];
			end
		end
	end

	assign sd_s5.vis = vis_s5;
	assign sd_s5.ctr = ctr_s5;
	for (genvar k = 0; k < NUM_AXES; k++) begin : g_pack
		assign sd_s5.num[k] = num_s5[k];
	end

	// Cross products for the pairwise distance comparisons.
	for (genvar q = 0; q < NUM_PAIRS; q++) begin : g_pair
		shtt_mul #(
			.AW (NUM_W),
			.BW (DEN_W)
		) u_pa (
			.clk (clk),
			.en  (adv),
			.a   (num_s5[PAIR_A[q]]),
			.b   (den_s5[PAIR_B[q]]),
			.p   (pa[q])
		);
		shtt_mul #(
			.AW (NUM_W),
			.BW (DEN_W)
		) u_pb (
			.clk (clk),
			.en  (adv),
			.a   (num_s5[PAIR_B[q]]),
			.b   (den_s5[PAIR_A[q]]),
			.p   (pb[q])
		);
	end

	// Threshold scaled by each denominator.
	for (genvar k = 0; k < NUM_AXES; k++) begin : g_thr
		shtt_mul #(
			.AW (NUM_W),
			.BW (DEN_W)
		) u_thr (
			.clk (clk),
			.en  (adv),
			.a   (NUM_W'(t2_q)),
			.b   (den_s5[k]),
			.p   (pthr[k])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd2_q[0] <= sd_s5;
			for (int i = 1; i < L2; i++) begin
				sd2_q[i] <= sd2_q[i-1];
			end
		end
	end
	assign sd2 = sd2_q[L2-1];

	// Stage 6: nearest axis below the threshold; ties go to Z, then Y, then X.
	for (genvar q = 0; q < NUM_PAIRS; q++) begin : g_lt
		assign lt[q] = pa[q] < pb[q];
	end
	for (genvar k = 0; k < NUM_AXES; k++) begin : g_below
		assign below[k] = CMP_W'(sd2.num[k]) < pthr[k];
	end

	assign win_z = below[AX_Z] && !lt[PAIR_YZ] && !lt[PAIR_XZ];
	assign win_y = below[AX_Y] && lt[PAIR_YZ] && !lt[PAIR_XY];
	assign win_x = below[AX_X] && lt[PAIR_XZ] && lt[PAIR_XY];

	always_comb begin
		if (!sd2.vis) begin
			hit_nx = HIT_NONE;
		end else if (sd2.ctr) begin
			hit_nx = HIT_CENTER;
		end else if (win_z) begin
			hit_nx = HIT_Z;
		end else if (win_y) begin
			hit_nx = HIT_Y;
		end else if (win_x) begin
			hit_nx = HIT_X;
		end else begin
			hit_nx = HIT_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s6 <= hit_nx;
		end
	end

	// Output holding stage: catches the last stage's result when the consumer stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (result.ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (v_s6 && !result.ready) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q && v_s6 && !result.ready) begin
			skid_hit_q <= hit_s6;
		end
	end

	assign result.valid      = skid_v_q || v_s6;
	assign result.hit_handle = skid_v_q ? skid_hit_q : hit_s6;

	// At most one axis can win the nearest-segment selection.
	a_one_winner: assert property (@(posedge clk) disable iff (!arst_n)
		vd2_q[L2-1] |-> $onehot0({win_z, win_y, win_x}))
		else $error("more than one axis selected as nearest");

	// The holding stage fills only from a stalled valid result.
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && !$past(skid_v_q)) |-> $past(v_s6 && !result.ready))
		else $error("holding stage filled without a stalled result");

	// An accepted transaction enters the first stage.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(query.valid && query.ready) |=> v_s1)
		else $error("accepted transaction lost at pipeline entry");

	// A radius write leaves its square in the compare register.
	a_radius_sq: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_idx == CFG_CENTER_RADIUS) |=>
		r2_q == SQR_W'($past(cfg_wdata)) * SQR_W'($past(cfg_wdata)))
		else $error("center radius square not stored");

endmodule

FILE: tb/segment_hit_test_three_axes_unit_tb.sv
// Self-checking testbench for the three-axis segment hit test unit.
module segment_hit_test_three_axes_unit_tb;
	import shtt_pkg::*;

	localparam int COORD_W      = COORD_WIDTH_DEF;
	localparam int WIDE_W       = 128;
	localparam int RESET_CYCLES = 7;
	localparam int DRAIN_CYCLES = 24;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int MAX_REPORTS  = 40;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);
	localparam logic [REG_W-1:0] REG_MAX          = {REG_W{1'b1}};
	localparam logic [REG_W-1:0] RADIUS_RESET     = REG_W'(CENTER_RADIUS_PX << COORD_FRAC_DEF);
	localparam logic [REG_W-1:0] THRESHOLD_RESET  = REG_W'(AXIS_THRESHOLD_PX << COORD_FRAC_DEF);

	typedef struct {
		logic                      visible;
		logic signed [COORD_W-1:0] touch_x;
		logic signed [COORD_W-1:0] touch_y;
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
		logic signed [COORD_W-1:0] tip_x_x;
		logic signed [COORD_W-1:0] tip_x_y;
		logic signed [COORD_W-1:0] tip_y_x;
		logic signed [COORD_W-1:0] tip_y_y;
		logic signed [COORD_W-1:0] tip_z_x;
		logic signed [COORD_W-1:0] tip_z_y;
	} touch_query_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [REG_W-1:0]     cfg_wdata;

	shtt_query_if #(.COORD_WIDTH(COORD_W)) touch_q ();
	shtt_result_if hit_r ();

	segment_hit_test_three_axes_unit #(
		.COORD_WIDTH    (COORD_W),
		.COORD_FRAC_BITS(COORD_FRAC_DEF)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.query    (touch_q),
		.result   (hit_r),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	// Expected hit codes in order, and the testbench's copy of the registers.
	hit_code_t        expected_hits [$];
	hit_code_t        want;
	logic [REG_W-1:0] radius_reg     = RADIUS_RESET;
	logic [REG_W-1:0] threshold_reg  = THRESHOLD_RESET;
	int               mismatches     = 0;
	int               send_idle_pct  = 0;
	int               recv_stall_pct = 0;
	int               hold_off_left  = 0;
	int               cycle_count    = 0;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: ends the run if the traffic never completes.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL segment_hit_test_three_axes_unit");
		$finish;
	end

	// Result ready: a long hold-off when asked, otherwise random stalls.
	initial begin
		hit_r.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_left > 0) begin
				hold_off_left--;
				hit_r.ready <= 1'b0;
			end else begin
				hit_r.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("MISMATCH at %0t: %s", $time, what);
	endtask

	// Every result transaction is compared with the oldest expected hit code.
	always @(posedge clk) begin
		if (arst_n && hit_r.valid && hit_r.ready) begin
			if (expected_hits.size() == 0) begin
				report_mismatch($sformatf("hit_handle %0d with no query outstanding",
					hit_r.hit_handle));
			end else begin
				want = expected_hits.pop_front();
				if (hit_r.hit_handle !== want)
					report_mismatch($sformatf("hit_handle %0d, expected %0d",
						hit_r.hit_handle, want));
			end
		end
	end

	// Squared distance from the touch to segment a-b as an exact ratio num/den.
	function automatic void segment_dist2(input longint tx, ty, ax, ay, bx, by,
			output logic [WIDE_W-1:0] num, output logic [WIDE_W-1:0] den);
		longint      vx, vy, wx, wy, c1, c2, cr;
		logic [63:0] mag;
		vx  = bx - ax;
		vy  = by - ay;
		wx  = tx - ax;
		wy  = ty - ay;
		c1  = wx * vx + wy * vy;
		c2  = vx * vx + vy * vy;
		den = WIDE_W'(1);
		if (c1 <= 0) begin
			num = WIDE_W'(wx * wx + wy * wy);
		end else if (c2 <= c1) begin
			num = WIDE_W'((tx - bx) * (tx - bx) + (ty - by) * (ty - by));
		end else begin
			// Perpendicular case: cross product squared over the segment length squared.
			cr  = wx * vy - wy * vx;
			mag = (cr < 0) ? -cr : cr;
			num = WIDE_W'(mag) * WIDE_W'(mag);
			den = WIDE_W'(c2);
		end
	endfunction

	// Hit code for one query under the given register values.
	function automatic hit_code_t predict_hit(input touch_query_t q,
			input logic [REG_W-1:0] radius, input logic [REG_W-1:0] thresh);
		longint            tx, ty, cx, cy, dx, dy;
		longint            tip_px [NUM_AXES];
		longint            tip_py [NUM_AXES];
		hit_code_t         codes  [NUM_AXES];
		logic [WIDE_W-1:0] best_num, best_den, d_num, d_den;
		hit_code_t         hit;
		int                k;
		if (!q.visible)
			return HIT_NONE;
		tx = longint'(q.touch_x);
		ty = longint'(q.touch_y);
		cx = longint'(q.center_x);
		cy = longint'(q.center_y);
		tip_px[AX_X] = longint'(q.tip_x_x);
		tip_py[AX_X] = longint'(q.tip_x_y);
		tip_px[AX_Y] = longint'(q.tip_y_x);
		tip_py[AX_Y] = longint'(q.tip_y_y);
		tip_px[AX_Z] = longint'(q.tip_z_x);
		tip_py[AX_Z] = longint'(q.tip_z_y);
		codes[AX_X]  = HIT_X;
		codes[AX_Y]  = HIT_Y;
		codes[AX_Z]  = HIT_Z;
		dx = tx - cx;
		dy = ty - cy;
		if (dx * dx + dy * dy < longint'(radius) * longint'(radius))
			return HIT_CENTER;
		// Slots run Z, Y, X; a strict test keeps the earlier slot on a tie.
		best_num = WIDE_W'(thresh) * WIDE_W'(thresh);
		best_den = WIDE_W'(1);
		hit      = HIT_NONE;
		for (k = 0; k < NUM_AXES; k++) begin
			segment_dist2(tx, ty, cx, cy, tip_px[k], tip_py[k], d_num, d_den);
			if (d_num * best_den < best_num * d_den) begin
				best_num = d_num;
				best_den = d_den;
				hit      = codes[k];
			end
		end
		return hit;
	endfunction

	// Builds a query; coordinates wrap to the port width.
	function automatic touch_query_t make_query(input logic vis,
			input longint tx, ty, cx, cy, xx, xy, yx, yy, zx, zy);
		touch_query_t q;
		q.visible  = vis;
		q.touch_x  = COORD_W'(tx);
		q.touch_y  = COORD_W'(ty);
		q.center_x = COORD_W'(cx);
		q.center_y = COORD_W'(cy);
		q.tip_x_x  = COORD_W'(xx);
		q.tip_x_y  = COORD_W'(xy);
		q.tip_y_x  = COORD_W'(yx);
		q.tip_y_y  = COORD_W'(yy);
		q.tip_z_x  = COORD_W'(zx);
		q.tip_z_y  = COORD_W'(zy);
		return q;
	endfunction

	function automatic longint spread(input int span);
		return longint'($urandom_range(2 * span)) - longint'(span);
	endfunction

	// Random query: a quarter pure noise, the rest a handle layout with the touch
	// near the center or near one of the segments, with point and duplicate tips.
	function automatic touch_query_t random_query();
		longint cx, cy, tx, ty, t;
		longint px [NUM_AXES];
		longint py [NUM_AXES];
		int     roll, span, k, pick;
		roll = $urandom_range(99);
		if (roll < 25)
			return make_query($urandom_range(9) != 0, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		cx = spread(32768);
		cy = spread(32768);
		case ($urandom_range(3))
			0: span = 300;
			1: span = 3000;
			2: span = 12000;
			default: span = 40000;
		endcase
		for (k = 0; k < NUM_AXES; k++) begin
			px[k] = cx + spread(span);
			py[k] = cy + spread(span);
			if ($urandom_range(9) == 0) begin
				px[k] = cx;
				py[k] = cy;
			end
		end
		if ($urandom_range(7) == 0) begin
			pick     = $urandom_range(NUM_AXES - 1);
			k        = (pick + 1) % NUM_AXES;
			px[k]    = px[pick];
			py[k]    = py[pick];
		end
		if (roll < 40) begin
			tx = cx + spread(int'(radius_reg) + 32);
			ty = cy + spread(int'(radius_reg) + 32);
		end else begin
			k  = $urandom_range(NUM_AXES - 1);
			t  = longint'($urandom_range(1400)) - 200;
			tx = cx + (px[k] - cx) * t / 1000 + spread(int'(threshold_reg) + 64);
			ty = cy + (py[k] - cy) * t / 1000 + spread(int'(threshold_reg) + 64);
		end
		return make_query($urandom_range(15) != 0, tx, ty, cx, cy,
			px[AX_X], py[AX_X], px[AX_Y], py[AX_Y], px[AX_Z], py[AX_Z]);
	endfunction

	// Offers one query and records its expected hit code once it is taken.
	task automatic send_query(input touch_query_t q);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			touch_q.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		touch_q.valid          <= 1'b1;
		touch_q.handle_visible <= q.visible;
		touch_q.touch_x        <= q.touch_x;
		touch_q.touch_y        <= q.touch_y;
		touch_q.center_x       <= q.center_x;
		touch_q.center_y       <= q.center_y;
		touch_q.tip_x_x        <= q.tip_x_x;
		touch_q.tip_x_y        <= q.tip_x_y;
		touch_q.tip_y_x        <= q.tip_y_x;
		touch_q.tip_y_y        <= q.tip_y_y;
		touch_q.tip_z_x        <= q.tip_z_x;
		touch_q.tip_z_y        <= q.tip_z_y;
		do @(posedge clk); while (!touch_q.ready);
		expected_hits.insert(expected_hits.size(), predict_hit(q, radius_reg, threshold_reg));
	endtask

	// Stops offering queries and waits until every result has come back.
	task automatic drain();
		touch_q.valid <= 1'b0;
		while (expected_hits.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_CENTER_RADIUS)
			radius_reg = value;
		else if (idx == CFG_AXIS_THRESHOLD)
			threshold_reg = value;
	endtask

	task automatic configure(input logic [REG_W-1:0] radius, input logic [REG_W-1:0] thresh);
		drain();
		write_reg(CFG_CENTER_RADIUS, radius);
		write_reg(CFG_AXIS_THRESHOLD, thresh);
	endtask

	// Hidden handles give none, even with the touch on the center.
	task automatic test_hidden_handles();
		touch_query_t q;
		send_query(make_query(1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		q         = random_query();
		q.visible = 1'b0;
		send_query(q);
	endtask

	// Center radius edge under the reset register values.
	task automatic test_center_radius();
		send_query(make_query(1'b1, 1720, -2000, 1000, -2000, -5000, -2000,
			1000, -8000, -3000, -6000));
		send_query(make_query(1'b1, 1719, -2000, 1000, -2000, -5000, -2000,
			1000, -8000, -3000, -6000));
		send_query(make_query(1'b1, 1432, -2576, 1000, -2000, -5000, -2000,
			1000, -8000, -3000, -6000));
		send_query(make_query(1'b1, 1432, -2575, 1000, -2000, -5000, -2000,
			1000, -8000, -3000, -6000));
	endtask

	// Writes to indexes past the register list must leave the radius alone.
	task automatic test_spare_index();
		drain();
		write_reg(CFG_SPARE_LO, '0);
		write_reg(CFG_SPARE_HI, '0);
		send_query(make_query(1'b1, 700, 0, 0, 0, 4000, 0, 0, 4000, -4000, -4000));
	endtask

	// Axis distance exactly at the threshold is no hit; one unit inside it is a hit.
	task automatic test_axis_threshold();
		configure(RADIUS_RESET, THRESHOLD_RESET);
		send_query(make_query(1'b1, 2000, 880, 0, 0, 4000, 0, 0, 4000, -4000, -4000));
		send_query(make_query(1'b1, 2000, 879, 0, 0, 4000, 0, 0, 4000, -4000, -4000));
		send_query(make_query(1'b1, 2000, -880, 0, 0, 4000, 0, 0, 4000, -4000, -4000));
		send_query(make_query(1'b1, 879, 2000, 0, 0, 4000, 0, 0, 4000, -4000, -4000));
	endtask

	task automatic test_zero_threshold();
		configure(RADIUS_RESET, '0);
		send_query(make_query(1'b1, 2000, 0, 0, 0, 4000, 0, 0, 4000, -4000, -4000));
	endtask

	// With no center radius a touch on the center is at zero from every axis.
	task automatic test_zero_radius();
		configure('0, THRESHOLD_RESET);
		send_query(make_query(1'b1, 500, 500, 500, 500, 4500, 500, 500, 4500, -3500, -3500));
		send_query(make_query(1'b1, 503, 500, 500, 500, 4500, 500, 500, 4500, -3500, -3500));
	endtask

	// Equal distances resolve to Z, then Y, then X.
	task automatic test_tie_order();
		configure(RADIUS_RESET, THRESHOLD_RESET);
		send_query(make_query(1'b1, 2000, 300, 0, 0, 0, 4000, 4000, 0, 4000, 0));
		send_query(make_query(1'b1, 2000, 300, 0, 0, 4000, 0, 4000, 0, -4000, 0));
		send_query(make_query(1'b1, 2000, 300, 0, 0, 4000, 0, 0, 4000, -4000, 0));
	endtask

	// Tips on the center make every segment a point.
	task automatic test_point_segments();
		send_query(make_query(1'b1, 900, 100, 100, 100, 100, 100, 100, 100, 100, 100));
		send_query(make_query(1'b1, 980, 100, 100, 100, 100, 100, 100, 100, 100, 100));
	endtask

	// Coordinate and register extremes, including the far end point case.
	task automatic test_coordinate_extremes();
		configure(REG_MAX, REG_MAX);
		send_query(make_query(1'b1, 32767, 32767, -32768, -32768, -32768, -32768,
			-32768, -32768, -32768, -32768));
		send_query(make_query(1'b1, 0, 0, -32768, 32767, 32767, 32767,
			-32768, -32768, 32767, -32768));
		send_query(make_query(1'b1, 32767, 0, 0, 0, 100, 0, 0, -32768, -32768, 0));
		send_query(make_query(1'b1, 32767, 32767, 32767, 32767, 32767, 32767,
			32767, 32767, 32767, 32767));
	endtask

	task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct,
			input logic [REG_W-1:0] radius, input logic [REG_W-1:0] thresh);
		configure(radius, thresh);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		repeat (count) send_query(random_query());
	endtask

	// The receiver holds off long enough to fill the pipeline, then the sender
	// pauses until every outstanding result is back.
	task automatic test_backpressure();
		configure(REG_W'($urandom_range(1500)), REG_W'($urandom_range(2500)));
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_off_left  = 300;
		repeat (80) send_query(random_query());
		drain();
		repeat (40) send_query(random_query());
	endtask

	// Test sequence.
	initial begin
		arst_n                 <= 1'b0;
		cfg_we                 <= 1'b0;
		cfg_idx                <= CFG_CENTER_RADIUS;
		cfg_wdata              <= '0;
		touch_q.valid          <= 1'b0;
		touch_q.handle_visible <= 1'b0;
		touch_q.touch_x        <= '0;
		touch_q.touch_y        <= '0;
		touch_q.center_x       <= '0;
		touch_q.center_y       <= '0;
		touch_q.tip_x_x        <= '0;
		touch_q.tip_x_y        <= '0;
		touch_q.tip_y_x        <= '0;
		touch_q.tip_y_y        <= '0;
		touch_q.tip_z_x        <= '0;
		touch_q.tip_z_y        <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_hidden_handles();
		test_center_radius();
		test_spare_index();
		test_axis_threshold();
		test_zero_threshold();
		test_zero_radius();
		test_tie_order();
		test_point_segments();
		test_coordinate_extremes();
		test_random_traffic(320, 0, 0, RADIUS_RESET, THRESHOLD_RESET);
		test_random_traffic(300, 75, 0, REG_W'($urandom_range(1500)),
			REG_W'($urandom_range(2500)));
		test_random_traffic(300, 0, 75, REG_W'($urandom_range(1500)),
			REG_W'($urandom_range(2500)));
		test_random_traffic(200, 27, 27, '0, REG_MAX);
		test_random_traffic(50, 27, 27, REG_MAX, '0);
		test_backpressure();

		drain();
		if (expected_hits.size() != 0)
			report_mismatch("results still outstanding at the end");
		if (mismatches == 0)
			$display("PASS segment_hit_test_three_axes_unit");
		else
			$display("FAIL segment_hit_test_three_axes_unit");
		$finish;
	end

endmodule
